// ----- design/krg_pkg.sv -----
package krg_pkg;

    localparam int WORD_W    = 32;
    localparam int DWORD_W   = 2 * WORD_W;
    localparam int SKIP_BITS = 32;
    // skip counts arrive on a 32-bit field, so at most 32 exponent bits matter
    localparam int CNT_W     = (SKIP_BITS < WORD_W) ? SKIP_BITS : WORD_W;
    localparam int COL_W     = $clog2(WORD_W);
    localparam int STEP_W    = $clog2(DWORD_W);
    localparam int ADDR_W    = 4;
    localparam int REG_LSB   = 2;

    localparam logic [WORD_W-1:0]  LCG_MUL = 32'd314527869;
    localparam logic [WORD_W-1:0]  LCG_ADD = 32'd1234567;
    localparam logic [WORD_W-1:0]  MWC_MUL = 32'd4294584393;
    // mwc modulus is MWC_MUL * 2^32 - 1
    localparam logic [DWORD_W-1:0] MWC_MOD = {MWC_MUL - 32'd1, 32'hFFFF_FFFF};

    localparam logic [WORD_W-1:0] SEED_X_RST = 32'd123456789;
    localparam logic [WORD_W-1:0] SEED_Y_RST = 32'd362436000;
    localparam logic [WORD_W-1:0] SEED_Z_RST = 32'd521288629;
    localparam logic [WORD_W-1:0] SEED_C_RST = 32'd7654321;

    typedef enum logic [1:0] {
        REQ_DRAW   = 2'd0,
        REQ_SKIP   = 2'd1,
        REQ_RELOAD = 2'd2
    } req_t;

    typedef enum logic [1:0] {
        KIND_VALUE  = 2'd0,
        KIND_SKIP   = 2'd1,
        KIND_RELOAD = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        REG_SEED_X = 2'd0,
        REG_SEED_Y = 2'd1,
        REG_SEED_Z = 2'd2,
        REG_SEED_C = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [WORD_W-1:0] skip_count;
    } krg_in_t;

    typedef struct packed {
        logic [1:0]        result_kind;
        logic [WORD_W-1:0] random_value;
    } krg_out_t;

    typedef struct packed {
        logic [WORD_W-1:0] x;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [WORD_W-1:0] c;
    } krg_seeds_t;

    typedef struct packed {
        logic  draw;
        logic  reload;
        logic  skip_init;
        logic  skip_prep;
        logic  lcg_jump;
        logic  aa_upd;
        logic  am_upd;
        logic  sq_col;
        logic  base_copy;
        logic  mul_start;
        logic  mul_sq;
        logic  y_load;
        logic  b_load;
        logic  exp_shift;
        logic  mwc_write;
        logic  out_load;
        kind_t out_kind;
    } krg_cmd_t;

    typedef struct packed {
        logic out_free;
        logic count_zero;
        logic n_bit;
        logic k_bit;
        logic n_rest_zero;
        logic k_rest_zero;
        logic loop;
        logic mul_done;
        logic col_last;
    } krg_status_t;

    // column i holds the image of bit i under one xorshift step
    typedef logic [WORD_W-1:0][WORD_W-1:0] xs_mat_t;

    function automatic logic [WORD_W-1:0] xs_step(input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] t;
        begin
            t = v ^ (v << 5);
            t = t ^ (t >> 7);
            t = t ^ (t << 22);
            return t;
        end
    endfunction

    function automatic logic [WORD_W-1:0] mat_apply(input xs_mat_t m,
                                                    input logic [WORD_W-1:0] v);
        logic [WORD_W-1:0] r;
        begin
            r = '0;
            for (int i = 0; i < WORD_W; i++)
            begin
                if (v[i])
                begin
                    r = r ^ m[i];
                end
            end
            return r;
        end
    endfunction

    function automatic xs_mat_t xs_base();
        xs_mat_t m;
        begin
            for (int i = 0; i < WORD_W; i++)
            begin
                m[i] = xs_step(WORD_W'(1) << i);
            end
            return m;
        end
    endfunction

    localparam xs_mat_t XS_BASE = xs_base();

endpackage

// ----- design/kiss_random_generator_top.sv -----
// channel   direction  handshake             beat
// in        input      in_valid / in_ready   req_type, skip_count
// out       output     out_valid / out_ready result_kind, random_value
// cfg       input      apb psel / penable    seed_x, seed_y, seed_z, seed_c at 0x0..0xc
//
// one request at a time; a draw first steps the state words and then registers their sum,
// while a reload or a zero skip loads its result beat on acceptance; a skip of n jumps
// ahead bit by bit over the count, with the lcg jump and xorshift matrix squaring and up
// to two modular multiplies of the mwc part per count bit
// in_ready is low while a request is in flight or while a result beat is held
// reset loads the seed registers and the state words with their default seeds
module kiss_random_generator_top (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  krg_pkg::krg_in_t           in_data,
    output logic                       out_valid,
    input  logic                       out_ready,
    output krg_pkg::krg_out_t          out_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [krg_pkg::ADDR_W-1:0] paddr,
    input  logic [krg_pkg::WORD_W-1:0] pwdata,
    output logic [krg_pkg::WORD_W-1:0] prdata,
    output logic                       pready
);
    import krg_pkg::*;

    krg_seeds_t  seeds;
    krg_cmd_t    cmd;
    krg_status_t status;

    krg_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .seeds   (seeds)
    );

    krg_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .req_type (in_data.req_type),
        .status   (status),
        .in_ready (in_ready),
        .cmd      (cmd)
    );

    krg_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .skip_count (in_data.skip_count),
        .seeds      (seeds),
        .out_ready  (out_ready),
        .out_valid  (out_valid),
        .out_data   (out_data),
        .status     (status)
    );

endmodule

// ----- design/krg_regs.sv -----
module krg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [krg_pkg::ADDR_W-1:0]     paddr,
    input  logic [krg_pkg::WORD_W-1:0]     pwdata,
    output logic [krg_pkg::WORD_W-1:0]     prdata,
    output logic                           pready,
    output krg_pkg::krg_seeds_t            seeds
);
    import krg_pkg::*;

    krg_seeds_t seeds_reg;
    krg_seeds_t seeds_next;
    logic [1:0] idx;

    assign idx    = paddr[ADDR_W-1:REG_LSB];
    assign pready = 1'b1;
    assign seeds  = seeds_reg;

    always_comb
    begin
        seeds_next = seeds_reg;
        if (psel && penable && pwrite)
        begin
            unique case (idx)
                REG_SEED_X: seeds_next.x = pwdata;
                REG_SEED_Y: seeds_next.y = pwdata;
                REG_SEED_Z: seeds_next.z = pwdata;
                REG_SEED_C: seeds_next.c = pwdata;
                default:    seeds_next = seeds_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_SEED_X: prdata = seeds_reg.x;
            REG_SEED_Y: prdata = seeds_reg.y;
            REG_SEED_Z: prdata = seeds_reg.z;
            REG_SEED_C: prdata = seeds_reg.c;
            default:    prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeds_reg.x <= SEED_X_RST;
            seeds_reg.y <= SEED_Y_RST;
            seeds_reg.z <= SEED_Z_RST;
            seeds_reg.c <= SEED_C_RST;
        end
        else
        begin
            seeds_reg <= seeds_next;
        end
    end

endmodule

// ----- design/krg_mulmod.sv -----
module krg_mulmod (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [krg_pkg::DWORD_W-1:0] a,
    input  logic [krg_pkg::DWORD_W-1:0] b,
    output logic                        done,
    output logic [krg_pkg::DWORD_W-1:0] product
);
    import krg_pkg::*;

    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(DWORD_W - 1);

    logic [DWORD_W-1:0] a_reg, a_next;
    logic [DWORD_W-1:0] b_reg, b_next;
    logic [DWORD_W-1:0] r_reg, r_next;
    logic [STEP_W-1:0]  cnt_reg, cnt_next;
    logic               phase_reg, phase_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [DWORD_W-1:0] addend;
    logic [DWORD_W:0]   sum;
    logic [DWORD_W:0]   diff;
    logic [DWORD_W-1:0] red;

    // one modular add per cycle: double on phase 0, add a on phase 1 when the top bit of b is set
    assign addend = phase_reg ? a_reg : r_reg;
    assign sum    = {1'b0, r_reg} + {1'b0, addend};
    assign diff   = sum - {1'b0, MWC_MOD};
    assign red    = diff[DWORD_W] ? sum[DWORD_W-1:0] : diff[DWORD_W-1:0];

    assign done    = done_reg;
    assign product = r_reg;

    always_comb
    begin
        a_next     = a_reg;
        b_next     = b_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        phase_next = phase_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            a_next     = a;
            b_next     = b;
            r_next     = '0;
            cnt_next   = '0;
            phase_next = 1'b0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!phase_reg)
            begin
                r_next     = red;
                phase_next = 1'b1;
            end
            else
            begin
                if (b_reg[DWORD_W-1])
                begin
                    r_next = red;
                end
                b_next     = b_reg << 1;
                phase_next = 1'b0;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == STEP_LAST)
                begin
                    busy_next = 1'b0;
                    done_next = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg   <= '0;
            phase_reg <= 1'b0;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg   <= cnt_next;
            phase_reg <= phase_next;
            busy_reg  <= busy_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next;
        b_reg <= b_next;
        r_reg <= r_next;
    end

endmodule

// ----- design/krg_datapath.sv -----
module krg_datapath (
    input  logic                       clk,
    input  logic                       rst_n,
    input  krg_pkg::krg_cmd_t          cmd,
    input  logic [krg_pkg::WORD_W-1:0] skip_count,
    input  krg_pkg::krg_seeds_t        seeds,
    input  logic                       out_ready,
    output logic                       out_valid,
    output krg_pkg::krg_out_t          out_data,
    output krg_pkg::krg_status_t       status
);
    import krg_pkg::*;

    logic [WORD_W-1:0]  lcg_reg, lcg_next;
    logic [WORD_W-1:0]  shift_reg, shift_next;
    logic [WORD_W-1:0]  mwcv_reg, mwcv_next;
    logic [WORD_W-1:0]  mwcc_reg, mwcc_next;
    logic [WORD_W-1:0]  am_reg, am_next;
    logic [WORD_W-1:0]  aa_reg, aa_next;
    xs_mat_t            base_reg, base_next;
    xs_mat_t            tmp_reg, tmp_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [CNT_W-1:0]   expn_reg, expn_next;
    logic [CNT_W-1:0]   expk_reg, expk_next;
    logic [DWORD_W-1:0] y_reg, y_next;
    logic [DWORD_W-1:0] bp_reg, bp_next;
    logic               loop_reg, loop_next;
    logic               out_valid_reg, out_valid_next;
    krg_out_t           out_data_reg, out_data_next;

    logic [WORD_W-1:0]  mac_a, mac_b, mac_c, mac_prod, mac_out;
    logic [DWORD_W-1:0] mwc_full, mwc_prod;
    logic [WORD_W-1:0]  apply_vec, apply_out, draw_sum;
    logic [CNT_W-1:0]   count_lo;
    logic [DWORD_W-1:0] mul_a, mul_prod;
    logic               mul_done;

    // shared 32-bit multiply-add for the congruential word and its jump terms
    always_comb
    begin
        mac_a = LCG_MUL;
        mac_b = lcg_reg;
        mac_c = LCG_ADD;
        if (cmd.lcg_jump)
        begin
            mac_a = am_reg;
            mac_c = aa_reg;
        end
        else if (cmd.aa_upd)
        begin
            mac_a = am_reg;
            mac_b = aa_reg;
            mac_c = aa_reg;
        end
        else if (cmd.am_upd)
        begin
            mac_a = am_reg;
            mac_b = am_reg;
            mac_c = '0;
        end
    end

    assign mac_prod = mac_a * mac_b;
    assign mac_out  = mac_prod + mac_c;

    assign mwc_full = DWORD_W'(MWC_MUL) * DWORD_W'(mwcv_reg);
    assign mwc_prod = mwc_full + DWORD_W'(mwcc_reg);

    assign apply_vec = cmd.sq_col ? base_reg[col_reg] : shift_reg;
    assign apply_out = mat_apply(base_reg, apply_vec);
    assign draw_sum  = lcg_reg + shift_reg + mwcv_reg;
    assign count_lo  = skip_count[CNT_W-1:0];

    assign mul_a = cmd.mul_sq ? bp_reg : y_reg;

    krg_mulmod u_mulmod (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cmd.mul_start),
        .a       (mul_a),
        .b       (bp_reg),
        .done    (mul_done),
        .product (mul_prod)
    );

    always_comb
    begin
        lcg_next   = lcg_reg;
        shift_next = shift_reg;
        mwcv_next  = mwcv_reg;
        mwcc_next  = mwcc_reg;
        am_next    = am_reg;
        aa_next    = aa_reg;
        base_next  = base_reg;
        tmp_next   = tmp_reg;
        col_next   = col_reg;
        expn_next  = expn_reg;
        expk_next  = expk_reg;
        y_next     = y_reg;
        bp_next    = bp_reg;
        loop_next  = loop_reg;

        if (cmd.draw)
        begin
            lcg_next   = mac_out;
            shift_next = xs_step(shift_reg);
            mwcc_next  = mwc_prod[DWORD_W-1:WORD_W];
            mwcv_next  = mwc_prod[WORD_W-1:0];
        end
        if (cmd.reload)
        begin
            lcg_next   = seeds.x;
            shift_next = seeds.y;
            mwcv_next  = seeds.z;
            mwcc_next  = seeds.c;
        end
        if (cmd.skip_init)
        begin
            expn_next = count_lo;
            expk_next = count_lo - 1'b1;
            am_next   = LCG_MUL;
            aa_next   = LCG_ADD;
            base_next = XS_BASE;
            // first mwc step is exact, the rest run modulo MWC_MOD
            y_next    = mwc_prod;
        end
        if (cmd.skip_prep)
        begin
            loop_next = (expk_reg != '0) && (y_reg != MWC_MOD);
            if ((expk_reg != '0) && (y_reg > MWC_MOD))
            begin
                y_next = y_reg - MWC_MOD;
            end
            bp_next = DWORD_W'(MWC_MUL);
        end
        if (cmd.lcg_jump)
        begin
            lcg_next   = mac_out;
            shift_next = apply_out;
        end
        if (cmd.aa_upd)
        begin
            aa_next = mac_out;
        end
        if (cmd.am_upd)
        begin
            am_next = mac_out;
        end
        if (cmd.sq_col)
        begin
            // columns shift in from the top, so column 0, computed first, ends at the bottom
            tmp_next = {apply_out, tmp_reg[WORD_W-1:1]};
            col_next = col_reg + 1'b1;
        end
        if (cmd.base_copy)
        begin
            base_next = tmp_reg;
        end
        if (cmd.y_load)
        begin
            y_next = mul_prod;
        end
        if (cmd.b_load)
        begin
            bp_next = mul_prod;
        end
        if (cmd.exp_shift)
        begin
            expn_next = expn_reg >> 1;
            expk_next = expk_reg >> 1;
        end
        if (cmd.mwc_write)
        begin
            mwcc_next = y_reg[DWORD_W-1:WORD_W];
            mwcv_next = y_reg[WORD_W-1:0];
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next             = 1'b1;
            out_data_next.result_kind  = cmd.out_kind;
            out_data_next.random_value = (cmd.out_kind == KIND_VALUE) ? draw_sum : '0;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign status.out_free    = !out_valid_reg || out_ready;
    assign status.count_zero  = (count_lo == '0);
    assign status.n_bit       = expn_reg[0];
    assign status.k_bit       = expk_reg[0];
    assign status.n_rest_zero = ((expn_reg >> 1) == '0);
    assign status.k_rest_zero = ((expk_reg >> 1) == '0);
    assign status.loop        = loop_reg;
    assign status.mul_done    = mul_done;
    assign status.col_last    = (col_reg == COL_W'(WORD_W - 1));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lcg_reg       <= SEED_X_RST;
            shift_reg     <= SEED_Y_RST;
            mwcv_reg      <= SEED_Z_RST;
            mwcc_reg      <= SEED_C_RST;
            col_reg       <= '0;
            expn_reg      <= '0;
            expk_reg      <= '0;
            loop_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            lcg_reg       <= lcg_next;
            shift_reg     <= shift_next;
            mwcv_reg      <= mwcv_next;
            mwcc_reg      <= mwcc_next;
            col_reg       <= col_next;
            expn_reg      <= expn_next;
            expk_reg      <= expk_next;
            loop_reg      <= loop_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg       <= am_next;
        aa_reg       <= aa_next;
        base_reg     <= base_next;
        tmp_reg      <= tmp_next;
        y_reg        <= y_next;
        bp_reg       <= bp_next;
        out_data_reg <= out_data_next;
    end

endmodule

// ----- design/krg_ctrl.sv -----
module krg_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            req_type,
    input  krg_pkg::krg_status_t  status,
    output logic                  in_ready,
    output krg_pkg::krg_cmd_t     cmd
);
    import krg_pkg::*;

    typedef enum logic [13:0] {
        ST_IDLE     = 14'd1,
        ST_DRAW_SUM = 14'd2,
        ST_SK_PREP  = 14'd4,
        ST_SK_LCG   = 14'd8,
        ST_SK_AA    = 14'd16,
        ST_SK_AM    = 14'd32,
        ST_SK_SQ    = 14'd64,
        ST_SK_COPY  = 14'd128,
        ST_SK_MWC   = 14'd256,
        ST_SK_MY    = 14'd512,
        ST_SK_MB    = 14'd1024,
        ST_SK_MBW   = 14'd2048,
        ST_SK_NEXT  = 14'd4096,
        ST_SK_DONE  = 14'd8192
    } state_t;

    state_t state_reg, state_next;
    logic   accept;

    assign in_ready = (state_reg == ST_IDLE) && status.out_free;
    assign accept   = in_valid && in_ready;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    unique case (req_type)
                        REQ_DRAW:
                        begin
                            cmd.draw   = 1'b1;
                            state_next = ST_DRAW_SUM;
                        end
                        REQ_SKIP:
                        begin
                            if (status.count_zero)
                            begin
                                cmd.out_load = 1'b1;
                                cmd.out_kind = KIND_SKIP;
                            end
                            else
                            begin
                                cmd.skip_init = 1'b1;
                                state_next    = ST_SK_PREP;
                            end
                        end
                        REQ_RELOAD:
                        begin
                            cmd.reload   = 1'b1;
                            cmd.out_load = 1'b1;
                            cmd.out_kind = KIND_RELOAD;
                        end
                        default:
                        begin
                            // unused request code: dropped without a result
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_DRAW_SUM:
            begin
                cmd.out_load = 1'b1;
                cmd.out_kind = KIND_VALUE;
                state_next   = ST_IDLE;
            end
            ST_SK_PREP:
            begin
                cmd.skip_prep = 1'b1;
                state_next    = ST_SK_LCG;
            end
            ST_SK_LCG:
            begin
                cmd.lcg_jump = status.n_bit;
                // after the top count bit the squared terms are not needed
                state_next   = status.n_rest_zero ? ST_SK_MWC : ST_SK_AA;
            end
            ST_SK_AA:
            begin
                cmd.aa_upd = 1'b1;
                state_next = ST_SK_AM;
            end
            ST_SK_AM:
            begin
                cmd.am_upd = 1'b1;
                state_next = ST_SK_SQ;
            end
            ST_SK_SQ:
            begin
                cmd.sq_col = 1'b1;
                if (status.col_last)
                begin
                    state_next = ST_SK_COPY;
                end
            end
            ST_SK_COPY:
            begin
                cmd.base_copy = 1'b1;
                state_next    = ST_SK_MWC;
            end
            ST_SK_MWC:
            begin
                if (status.loop && status.k_bit)
                begin
                    cmd.mul_start = 1'b1;
                    state_next    = ST_SK_MY;
                end
                else
                begin
                    state_next = ST_SK_MB;
                end
            end
            ST_SK_MY:
            begin
                if (status.mul_done)
                begin
                    cmd.y_load = 1'b1;
                    state_next = ST_SK_MB;
                end
            end
            ST_SK_MB:
            begin
                if (status.loop && !status.k_rest_zero)
                begin
                    cmd.mul_start = 1'b1;
                    cmd.mul_sq    = 1'b1;
                    state_next    = ST_SK_MBW;
                end
                else
                begin
                    state_next = ST_SK_NEXT;
                end
            end
            ST_SK_MBW:
            begin
                cmd.mul_sq = 1'b1;
                if (status.mul_done)
                begin
                    cmd.b_load = 1'b1;
                    state_next = ST_SK_NEXT;
                end
            end
            ST_SK_NEXT:
            begin
                cmd.exp_shift = 1'b1;
                state_next    = status.n_rest_zero ? ST_SK_DONE : ST_SK_LCG;
            end
            ST_SK_DONE:
            begin
                cmd.mwc_write = 1'b1;
                cmd.out_load  = 1'b1;
                cmd.out_kind  = KIND_SKIP;
                state_next    = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule
